// ===== rtl/core/hcb_pkg.sv =====
// ----------------------------------------------------------------------------
// hcb_pkg
// Shared types and constants of the Huffman code builder.
// ----------------------------------------------------------------------------
`default_nettype none

package hcb_pkg;

    // Stream payload widths (fixed by the item layout)
    localparam int IN_DATA_W   = 16;
    localparam int WEIGHT_IN_W = 16;
    localparam int SYM_OUT_W   = 4;
    localparam int CODE_W      = 15;
    localparam int LEN_W       = 4;
    localparam int OUT_DATA_W  = 24;

    // Branch labels
    localparam logic BIT_LEFT  = 1'b0;
    localparam logic BIT_RIGHT = 1'b1;

    // Longest code kept, length saturates here
    localparam logic [LEN_W-1:0] CODE_LEN_MAX = 4'd15;

    typedef enum logic [3:0] {
        S_LOAD,
        S_SCAN1,
        S_SCAN2,
        S_MERGE_A,
        S_MERGE_B,
        S_E_HEAD,
        S_E_PAR,
        S_E_BIT,
        S_E_OUT
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/core/hcb_ram.sv =====
// ----------------------------------------------------------------------------
// hcb_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module hcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/core/huffman_code_builder.sv =====
// ----------------------------------------------------------------------------
// huffman_code_builder
// Collects symbol weights, builds a Huffman tree, streams one code per symbol.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one weight per beat, in symbol order; tlast marks the
//   final weight of a set, and the MAX_SYMBOLS-th weight closes the set anyway.
//   o_s_tready is high only while weights are being collected (one beat per
//   cycle). After the closing beat the block builds the tree in its node
//   store: N-1 merges, each two compare passes over the nodes made so far
//   through one shared comparator and the weight RAM read port. Then it
//   walks each leaf's parent chain through the parent and left RAMs.
//   Master stream carries one code per beat in symbol order, tlast on the
//   final symbol. A set of one weight gives no beats.
//   Output is a register: when the receiver stalls, the walk waits on the
//   pending code; after the final code is loaded, collection resumes at once.
//   Reset (synchronous, active low) clears the weight count, the sequencer
//   and the output valid; the node RAMs are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_code_builder
    import hcb_pkg::*;
#(
    parameter int MAX_SYMBOLS = 16,
    parameter int WEIGHT_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // slave stream
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    input  wire logic [IN_DATA_W-1:0]  i_s_tdata,   // [15:0] weight
    input  wire logic                  i_s_tlast,   // last
    // master stream
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    output logic      [OUT_DATA_W-1:0] o_m_tdata,   // [3:0] symbol, [18:4] code_bits,
                                                    // [22:19] code_length, [23] zero
    output logic                       o_m_tlast    // last_code
);

    localparam int NODE_COUNT = 2 * MAX_SYMBOLS - 1;
    localparam int IDX_W      = $clog2(NODE_COUNT);
    localparam int CNT_W      = $clog2(MAX_SYMBOLS + 1);
    localparam int SUM_W      = WEIGHT_BITS + $clog2(MAX_SYMBOLS);
    localparam int IN_W       = (WEIGHT_BITS < WEIGHT_IN_W) ? WEIGHT_BITS : WEIGHT_IN_W;
    localparam int SYM_W      = (CNT_W > SYM_OUT_W) ? CNT_W : SYM_OUT_W;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state                  r_state, n_state;
    logic [CNT_W-1:0]        r_cnt, n_cnt;           // weights held
    logic [CNT_W-1:0]        r_n, n_n;               // symbols in the set
    logic [IDX_W-1:0]        r_top, n_top;           // next node to create
    logic [NODE_COUNT-1:0]   r_has_par, n_has_par;   // parent valid bits

    // scan pipeline
    logic [IDX_W-1:0]        r_iss, n_iss;
    logic                    r_iss_act, n_iss_act;
    logic                    r_cmp_vld, n_cmp_vld;
    logic [IDX_W-1:0]        r_cmp_idx, n_cmp_idx;
    logic                    r_found, n_found;
    logic [IDX_W-1:0]        r_best_idx, n_best_idx;
    logic [SUM_W-1:0]        r_best_w, n_best_w;
    logic [IDX_W-1:0]        r_first, n_first;
    logic [SUM_W-1:0]        r_first_w, n_first_w;

    // code walk
    logic [SYM_W-1:0]        r_sym, n_sym;
    logic [IDX_W-1:0]        r_cur, n_cur;
    logic [IDX_W-1:0]        r_par, n_par;
    logic [CODE_W-1:0]       r_bits, n_bits;
    logic [LEN_W-1:0]        r_len, n_len;

    // output register
    logic                    r_out_vld, n_out_vld;
    logic [OUT_DATA_W-1:0]   r_out_data, n_out_data;
    logic                    r_out_last, n_out_last;

    // ------------------------------------------------------------------
    // Node store
    // ------------------------------------------------------------------
    logic              wt_we;
    logic [IDX_W-1:0]  wt_waddr;
    logic [SUM_W-1:0]  wt_wdata;
    logic [SUM_W-1:0]  wt_rdata;
    logic              par_we;
    logic [IDX_W-1:0]  par_waddr;
    logic [IDX_W-1:0]  par_raddr;
    logic [IDX_W-1:0]  par_rdata;
    logic              lft_we;
    logic [IDX_W-1:0]  lft_rdata;

    hcb_ram #(.WIDTH(SUM_W), .DEPTH(NODE_COUNT)) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (wt_we),
        .i_waddr (wt_waddr),
        .i_wdata (wt_wdata),
        .i_raddr (r_iss),
        .o_rdata (wt_rdata)
    );

    hcb_ram #(.WIDTH(IDX_W), .DEPTH(NODE_COUNT)) u_parent_ram (
        .i_clk   (i_clk),
        .i_we    (par_we),
        .i_waddr (par_waddr),
        .i_wdata (r_top),
        .i_raddr (par_raddr),
        .o_rdata (par_rdata)
    );

    hcb_ram #(.WIDTH(IDX_W), .DEPTH(NODE_COUNT)) u_left_ram (
        .i_clk   (i_clk),
        .i_we    (lft_we),
        .i_waddr (r_top),
        .i_wdata (r_best_idx),
        .i_raddr (par_rdata),
        .o_rdata (lft_rdata)
    );

    // ------------------------------------------------------------------
    // Shared compare unit and helpers
    // ------------------------------------------------------------------
    logic              in_acc;
    logic              set_end;
    logic              pass2;
    logic              cand_skip;
    logic              cand_take;
    logic              scan_done;
    logic              out_load;
    logic              sym_last;
    logic              code_bit;
    logic [IDX_W-1:0]  root_idx;
    logic [SUM_W-1:0]  weight_in;
    logic [SUM_W-1:0]  weight_sum;

    assign in_acc     = i_s_tvalid && o_s_tready;
    assign set_end    = i_s_tlast || (r_cnt == CNT_W'(MAX_SYMBOLS - 1));
    assign weight_in  = SUM_W'(i_s_tdata[IN_W-1:0]);
    assign weight_sum = r_first_w + r_best_w;   // cannot exceed SUM_W bits

    assign pass2      = (r_state == S_SCAN2);
    assign cand_skip  = r_has_par[r_cmp_idx] || (pass2 && (r_cmp_idx == r_first));
    // lightest: earliest on ties; second: latest on ties
    assign cand_take  = !r_found ||
                        (pass2 ? (wt_rdata <= r_best_w) : (wt_rdata < r_best_w));
    assign scan_done  = !r_iss_act && !r_cmp_vld;

    assign root_idx   = IDX_W'({r_n, 1'b0}) - IDX_W'(2);
    assign out_load   = (r_state == S_E_OUT) && (!r_out_vld || i_m_tready);
    assign sym_last   = (r_sym == SYM_W'(r_n - CNT_W'(1)));
    assign code_bit   = (lft_rdata == r_cur) ? BIT_LEFT : BIT_RIGHT;

    assign o_s_tready = (r_state == S_LOAD);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_n        = r_n;
        n_top      = r_top;
        n_has_par  = r_has_par;
        n_iss      = r_iss;
        n_iss_act  = r_iss_act;
        n_cmp_vld  = 1'b0;
        n_cmp_idx  = r_iss;
        n_found    = r_found;
        n_best_idx = r_best_idx;
        n_best_w   = r_best_w;
        n_first    = r_first;
        n_first_w  = r_first_w;
        n_sym      = r_sym;
        n_cur      = r_cur;
        n_par      = r_par;
        n_bits     = r_bits;
        n_len      = r_len;
        n_out_vld  = r_out_vld && !i_m_tready;
        n_out_data = r_out_data;
        n_out_last = r_out_last;

        wt_we      = 1'b0;
        wt_waddr   = IDX_W'(r_cnt);
        wt_wdata   = weight_in;
        par_we     = 1'b0;
        par_waddr  = r_first;
        par_raddr  = r_cur;
        lft_we     = 1'b0;

        // scan issue and compare stages run in both passes
        if (r_state == S_SCAN1 || r_state == S_SCAN2) begin
            if (r_iss_act) begin
                n_cmp_vld = 1'b1;
                n_iss     = r_iss + IDX_W'(1);
                if (r_iss == r_top - IDX_W'(1)) begin
                    n_iss_act = 1'b0;
                end
            end
            if (r_cmp_vld && !cand_skip && cand_take) begin
                n_found    = 1'b1;
                n_best_idx = r_cmp_idx;
                n_best_w   = wt_rdata;
            end
        end

        unique case (r_state)
            S_LOAD: begin
                if (in_acc) begin
                    wt_we = 1'b1;
                    n_cnt = r_cnt + CNT_W'(1);
                    if (set_end) begin
                        n_cnt = '0;
                        if (r_cnt != '0) begin
                            n_n       = r_cnt + CNT_W'(1);
                            n_top     = IDX_W'(r_cnt) + IDX_W'(1);
                            n_has_par = '0;
                            n_iss     = '0;
                            n_iss_act = 1'b1;
                            n_found   = 1'b0;
                            n_state   = S_SCAN1;
                        end
                    end
                end
            end
            S_SCAN1: begin
                if (scan_done) begin
                    n_first   = r_best_idx;
                    n_first_w = r_best_w;
                    n_iss     = '0;
                    n_iss_act = 1'b1;
                    n_found   = 1'b0;
                    n_state   = S_SCAN2;
                end
            end
            S_SCAN2: begin
                if (scan_done) begin
                    n_state = S_MERGE_A;
                end
            end
            S_MERGE_A: begin
                // new node: weight sum, left child; first child gets parent
                wt_we              = 1'b1;
                wt_waddr           = r_top;
                wt_wdata           = weight_sum;
                lft_we             = 1'b1;
                par_we             = 1'b1;
                par_waddr          = r_first;
                n_has_par[r_first] = 1'b1;
                n_state            = S_MERGE_B;
            end
            S_MERGE_B: begin
                par_we                = 1'b1;
                par_waddr             = r_best_idx;
                n_has_par[r_best_idx] = 1'b1;
                n_top                 = r_top + IDX_W'(1);
                n_iss                 = '0;
                if (r_top == root_idx) begin
                    n_sym   = '0;
                    n_cur   = '0;
                    n_bits  = '0;
                    n_len   = '0;
                    n_state = S_E_HEAD;
                end else begin
                    n_iss_act = 1'b1;
                    n_found   = 1'b0;
                    n_state   = S_SCAN1;
                end
            end
            S_E_HEAD: begin
                // every leaf has a parent once the tree is complete
                par_raddr = r_cur;
                n_state   = r_has_par[r_cur] ? S_E_PAR : S_E_OUT;
            end
            S_E_PAR: begin
                n_par   = par_rdata;
                n_state = S_E_BIT;
            end
            S_E_BIT: begin
                par_raddr = r_par;
                if (r_len < CODE_LEN_MAX) begin
                    n_bits = r_bits | (CODE_W'(code_bit) << r_len);
                    n_len  = r_len + LEN_W'(1);
                end
                n_cur   = r_par;
                n_state = r_has_par[r_par] ? S_E_PAR : S_E_OUT;
            end
            S_E_OUT: begin
                if (out_load) begin
                    n_out_vld  = 1'b1;
                    n_out_data = {1'b0, r_len, r_bits, r_sym[SYM_OUT_W-1:0]};
                    n_out_last = sym_last;
                    if (sym_last) begin
                        n_state = S_LOAD;
                    end else begin
                        n_sym   = r_sym + SYM_W'(1);
                        n_cur   = IDX_W'(r_sym + SYM_W'(1));
                        n_bits  = '0;
                        n_len   = '0;
                        n_state = S_E_HEAD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_cnt     <= '0;
            r_iss_act <= 1'b0;
            r_cmp_vld <= 1'b0;
            r_found   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_iss_act <= n_iss_act;
            r_cmp_vld <= n_cmp_vld;
            r_found   <= n_found;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n        <= n_n;
        r_top      <= n_top;
        r_has_par  <= n_has_par;
        r_iss      <= n_iss;
        r_cmp_idx  <= n_cmp_idx;
        r_best_idx <= n_best_idx;
        r_best_w   <= n_best_w;
        r_first    <= n_first;
        r_first_w  <= n_first_w;
        r_sym      <= n_sym;
        r_cur      <= n_cur;
        r_par      <= n_par;
        r_bits     <= n_bits;
        r_len      <= n_len;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

`ifndef ASSERT_OFF
    // each merge step marks exactly one more node as parented
    a_merge_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MERGE_A || r_state == S_MERGE_B) |=>
            ($countones(r_has_par) == $past($countones(r_has_par)) + 1))
        else $error("merge did not mark a new child");

    // every emitted code is at least one bit long
    a_code_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_E_OUT) |-> (r_len != '0))
        else $error("empty code");

    // the final code returns the block to collection
    a_last_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && sym_last) |=> (r_state == S_LOAD && o_m_tlast))
        else $error("final code did not end the set");

    // scanning never runs past the nodes built so far
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmp_vld |-> (r_cmp_idx < r_top))
        else $error("scan index beyond top");
`endif

endmodule

`default_nettype wire
